// File: design/assert_macros.svh
// Assertion macros shared by the and-inverter graph evaluator modules.
// Every macro reports through $error and is disabled while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that is checked at each rising edge outside reset.
`define AIGW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: when the antecedent holds, the consequent holds in the next cycle.
`define AIGW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/aigw_pkg.sv
// Shared types and constants of the and-inverter graph word evaluator.
// No dependencies; imported by the controller, the datapath and the top module.
`timescale 1ns / 1ps
`default_nettype none

package aigw_pkg;

    localparam int MAX_NODES = 4096;
    localparam int ADDR_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);

    localparam int SLOT_W  = 12;
    localparam int WORD_W  = 64;
    localparam int BLOCK_W = 16;
    localparam int SEED_W  = 32;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SEED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GEN_INPUTS = 1'd1;

    localparam logic [SEED_W-1:0] LCG_MUL   = 32'd1103515245;
    localparam logic [SEED_W-1:0] LCG_ADD   = 32'd12345;
    localparam logic [SEED_W-1:0] SEED_STEP = 32'd97;

    localparam int S_TDATA_W = 120;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 2;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_INPUT = 2'd1,
        FUNC_AND   = 2'd2,
        FUNC_READ  = 2'd3
    } t_func;

    localparam logic KIND_NODE   = 1'b0;
    localparam logic KIND_OUTPUT = 1'b1;

    typedef struct packed {
        logic [BLOCK_W-1:0] block_index;
        logic [WORD_W-1:0]  input_word;
        logic [SLOT_W-1:0]  fanin_a;
        logic [SLOT_W-1:0]  fanin_b;
        logic               invert_a;
        logic               invert_b;
        logic [SLOT_W-1:0]  output_node;
        logic               output_invert;
    } t_item;

    // Commands from the controller; at most one is active in a cycle.
    typedef struct packed {
        logic start;
        logic full_err;
        logic ext_store;
        logic lcg_lo;
        logic lcg_hi;
        logic rd_issue;
        logic and_done;
        logic out_done;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic gen_inputs;
    } t_status;

endpackage

`default_nettype wire

// File: design/aigw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module aigw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: design/aigw_ctrl.sv
// Controller of the graph evaluator: sequences each request and owns the
// handshakes. Depends on aigw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module aigw_ctrl
    import aigw_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    input  wire t_func   i_func,
    input  wire logic    i_m_tready,
    input  wire t_status i_status,
    output logic         o_s_tready,
    output logic         o_m_tvalid,
    output t_cmd         o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_GEN_HI,
        S_AND,
        S_READ
    } t_state;

    t_state r_state, n_state;
    logic   r_m_tvalid, n_m_tvalid;
    logic   accept;
    logic   emit;
    t_cmd   cmd;

    // A new request is taken only when its result, if any, has somewhere to go.
    assign o_s_tready = (r_state == S_IDLE) && (!r_m_tvalid || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_func)
                        FUNC_START: begin
                            cmd.start = 1'b1;
                        end
                        FUNC_INPUT: begin
                            if (i_status.full) begin
                                cmd.full_err = 1'b1;
                            end else if (i_status.gen_inputs) begin
                                cmd.lcg_lo = 1'b1;
                                n_state    = S_GEN_HI;
                            end else begin
                                cmd.ext_store = 1'b1;
                            end
                        end
                        FUNC_AND: begin
                            if (i_status.full) begin
                                cmd.full_err = 1'b1;
                            end else begin
                                cmd.rd_issue = 1'b1;
                                n_state      = S_AND;
                            end
                        end
                        FUNC_READ: begin
                            cmd.rd_issue = 1'b1;
                            n_state      = S_READ;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_GEN_HI: begin
                cmd.lcg_hi = 1'b1;
                n_state    = S_IDLE;
            end
            S_AND: begin
                cmd.and_done = 1'b1;
                n_state      = S_IDLE;
            end
            S_READ: begin
                cmd.out_done = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign emit = cmd.full_err | cmd.ext_store | cmd.lcg_hi | cmd.and_done | cmd.out_done;

    always_comb begin
        if (emit) begin
            n_m_tvalid = 1'b1;
        end else if (i_m_tready) begin
            n_m_tvalid = 1'b0;
        end else begin
            n_m_tvalid = r_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_cmd      = cmd;

    `AIGW_ASSERT(a_emit_room, i_clk, i_rst_n, !emit || !r_m_tvalid || i_m_tready, "result overwrites an untaken result")
    `AIGW_ASSERT_NEXT(a_busy_one_cycle, i_clk, i_rst_n, r_state != S_IDLE, r_state == S_IDLE, "controller busy for more than one cycle")
    `AIGW_ASSERT_NEXT(a_and_reads, i_clk, i_rst_n, accept && i_func == FUNC_AND && !i_status.full, r_state == S_AND, "AND request did not enter its read cycle")

endmodule

`default_nettype wire

// File: design/aigw_datapath.sv
// Datapath of the graph evaluator: configuration, generator, node counter,
// node memory and the result register. Depends on aigw_pkg, aigw_ram and
// assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module aigw_datapath
    import aigw_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire t_func                 i_func,
    input  wire t_item                 i_item,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    output logic                       o_result_kind,
    output logic [SLOT_W-1:0]          o_slot_index,
    output logic [WORD_W-1:0]          o_word_value,
    output logic                       o_capacity_error
);

    logic [SEED_W-1:0] r_base_seed;
    logic              r_gen_inputs;
    logic [SEED_W-1:0] r_gen;
    logic [CNT_W-1:0]  r_next_slot;

    // Operand controls captured with the request for the read cycle.
    logic              r_ok_a, r_ok_b, r_inv_a, r_inv_b;
    logic [SLOT_W-1:0] r_out_slot;

    logic              r_result_kind;
    logic [SLOT_W-1:0] r_slot_index;
    logic [WORD_W-1:0] r_word_value;
    logic              r_capacity_error;

    logic [SEED_W-1:0] gen_step;
    logic [SEED_W-1:0] block_seed;
    logic              full;
    logic              is_read;
    logic [ADDR_W-1:0] raddr_a, raddr_b, waddr;
    logic [WORD_W-1:0] rdata_a, rdata_b;
    logic [WORD_W-1:0] op_a, op_b;
    logic [WORD_W-1:0] wdata;
    logic              we;
    logic              emit;

    assign gen_step   = r_gen * LCG_MUL + LCG_ADD;
    assign block_seed = r_base_seed + SEED_W'(i_item.block_index) * SEED_STEP;
    assign full       = (r_next_slot == CNT_W'(MAX_NODES));

    assign o_status.full       = full;
    assign o_status.gen_inputs = r_gen_inputs;

    // Port A also serves output reads.
    assign is_read = (i_func == FUNC_READ);
    assign raddr_a = is_read ? ADDR_W'(i_item.output_node) : ADDR_W'(i_item.fanin_a);
    assign raddr_b = ADDR_W'(i_item.fanin_b);
    assign waddr   = ADDR_W'(r_next_slot);

    // Two copies of the node store give the two reads an AND node needs.
    aigw_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAX_NODES)
    ) u_ram_a (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr_a),
        .o_rdata(rdata_a)
    );

    aigw_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAX_NODES)
    ) u_ram_b (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr_b),
        .o_rdata(rdata_b)
    );

    // A slot outside the store reads as zero before inversion.
    assign op_a = (r_ok_a ? rdata_a : '0) ^ {WORD_W{r_inv_a}};
    assign op_b = (r_ok_b ? rdata_b : '0) ^ {WORD_W{r_inv_b}};

    always_comb begin
        priority if (i_cmd.lcg_hi) begin
            wdata = {gen_step, r_gen};
        end else if (i_cmd.and_done) begin
            wdata = op_a & op_b;
        end else begin
            wdata = i_item.input_word;
        end
    end

    assign we   = i_cmd.ext_store | i_cmd.lcg_hi | i_cmd.and_done;
    assign emit = we | i_cmd.full_err | i_cmd.out_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_seed  <= '0;
            r_gen_inputs <= 1'b1;
            r_gen        <= '0;
            r_next_slot  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BASE_SEED:  r_base_seed  <= i_cfg_wdata;
                    CFG_GEN_INPUTS: r_gen_inputs <= i_cfg_wdata[0];
                    default:        r_gen_inputs <= r_gen_inputs;
                endcase
            end
            if (i_cmd.start) begin
                r_gen       <= block_seed;
                r_next_slot <= '0;
            end else begin
                if (i_cmd.lcg_lo || i_cmd.lcg_hi) begin
                    r_gen <= gen_step;
                end
                if (we) begin
                    r_next_slot <= r_next_slot + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_ok_a     <= is_read ? (32'(i_item.output_node) < 32'(MAX_NODES))
                                  : (32'(i_item.fanin_a) < 32'(MAX_NODES));
            r_ok_b     <= 32'(i_item.fanin_b) < 32'(MAX_NODES);
            r_inv_a    <= is_read ? i_item.output_invert : i_item.invert_a;
            r_inv_b    <= i_item.invert_b;
            r_out_slot <= i_item.output_node;
        end
        if (emit) begin
            if (i_cmd.full_err) begin
                r_result_kind    <= KIND_NODE;
                r_slot_index     <= '0;
                r_word_value     <= '0;
                r_capacity_error <= 1'b1;
            end else if (i_cmd.out_done) begin
                r_result_kind    <= KIND_OUTPUT;
                r_slot_index     <= r_out_slot;
                r_word_value     <= op_a;
                r_capacity_error <= 1'b0;
            end else begin
                r_result_kind    <= KIND_NODE;
                r_slot_index     <= SLOT_W'(r_next_slot);
                r_word_value     <= wdata;
                r_capacity_error <= 1'b0;
            end
        end
    end

    assign o_result_kind    = r_result_kind;
    assign o_slot_index     = r_slot_index;
    assign o_word_value     = r_word_value;
    assign o_capacity_error = r_capacity_error;

    `AIGW_ASSERT(a_slot_bound, i_clk, i_rst_n, r_next_slot <= CNT_W'(MAX_NODES), "node counter past capacity")
    `AIGW_ASSERT(a_no_write_full, i_clk, i_rst_n, !we || !full, "node written into a full store")
    `AIGW_ASSERT_NEXT(a_gen_pair, i_clk, i_rst_n, i_cmd.lcg_lo, i_cmd.lcg_hi, "generator low half without high half")

endmodule

`default_nettype wire

// File: design/and_inverter_graph_word_evaluator.sv
// Evaluates an and-inverter graph on 64 patterns per word, one request at a
// time. A start request reseeds the pattern generator and restarts node
// numbering at slot zero, while stored words keep their values; primary-input
// and AND requests append a node and return its word; a read request returns
// a stored word, optionally complemented. Start, external primary inputs and
// requests dropped for a full store finish when taken; AND nodes and output
// reads add a state for the registered node-memory read; generated primary
// inputs add one for the high half, one generator step per cycle. A new request
// is taken only while the result register is empty or being read in the same
// cycle, so a waiting result holds off the input. The node store needs no
// clearing after reset. Depends on aigw_pkg, aigw_ctrl and aigw_datapath.
`timescale 1ns / 1ps
`default_nettype none

module and_inverter_graph_word_evaluator
    import aigw_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // tdata, low bit up: block_index[15:0], input_word[79:16], fanin_a[91:80],
    // fanin_b[103:92], invert_a[104], invert_b[105], output_node[117:106],
    // output_invert[118], zero[119].
    input  wire logic [S_TDATA_W-1:0]  i_s_tdata,
    // tuser: func[1:0].
    input  wire logic [S_TUSER_W-1:0]  i_s_tuser,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // tdata, low bit up: slot_index[11:0], word_value[75:12], zero[79:76].
    output logic [M_TDATA_W-1:0]       o_m_tdata,
    // tuser, low bit up: result_kind[0], capacity_error[1].
    output logic [M_TUSER_W-1:0]       o_m_tuser
);

    t_func             func;
    t_item             item;
    t_cmd              cmd;
    t_status           status;
    logic              result_kind;
    logic [SLOT_W-1:0] slot_index;
    logic [WORD_W-1:0] word_value;
    logic              capacity_error;

    assign func               = t_func'(i_s_tuser);
    assign item.block_index   = i_s_tdata[15:0];
    assign item.input_word    = i_s_tdata[79:16];
    assign item.fanin_a       = i_s_tdata[91:80];
    assign item.fanin_b       = i_s_tdata[103:92];
    assign item.invert_a      = i_s_tdata[104];
    assign item.invert_b      = i_s_tdata[105];
    assign item.output_node   = i_s_tdata[117:106];
    assign item.output_invert = i_s_tdata[118];

    aigw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .i_func    (func),
        .i_m_tready(i_m_tready),
        .i_status  (status),
        .o_s_tready(o_s_tready),
        .o_m_tvalid(o_m_tvalid),
        .o_cmd     (cmd)
    );

    aigw_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_func          (func),
        .i_item          (item),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_result_kind   (result_kind),
        .o_slot_index    (slot_index),
        .o_word_value    (word_value),
        .o_capacity_error(capacity_error)
    );

    assign o_m_tdata = {4'b0000, word_value, slot_index};
    assign o_m_tuser = {capacity_error, result_kind};

endmodule

`default_nettype wire
